[hdl/cdoa_pkg.sv]
// Shared types, constants and calendar helpers of the calendar date offset adder.
// Used by cdoa_ctrl, cdoa_datapath and calendar_date_offset_adder; no dependencies.
`default_nettype none

package cdoa_pkg;

   typedef enum logic [1:0] {
      CMD_ADD_DAYS   = 2'd0,
      CMD_ADD_MONTHS = 2'd1,
      CMD_ADD_YEARS  = 2'd2,
      CMD_NOP        = 2'd3
   } cmd_code_type;

   typedef struct packed {
      cmd_code_type       cmd;
      logic [13:0]        in_year;
      logic [3:0]         in_month;
      logic [4:0]         in_day;
      logic signed [15:0] amount;
   } req_type;

   typedef struct packed {
      logic [13:0] out_year;
      logic [3:0]  out_month;
      logic [4:0]  out_day;
      logic [15:0] epoch_days;
      logic        range_error;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic day_step;
      logic div_step;
      logic div_apply;
      logic year_add;
      logic fix;
      logic store;
   } ctl_cmd_type;

   typedef struct packed {
      cmd_code_type cmd;
      logic         day_fit;
   } ctl_status_type;

   localparam int YEAR_W    = 18;
   localparam int CNT_W     = 17;
   localparam int DIV_BITS  = 17;
   localparam int QUO_W     = 13;
   localparam int DIV_SHIFT = 19;

   localparam logic [3:0]               MONTHS     = 4'd12;
   localparam logic [DIV_BITS-1:0]      DIV_OFFSET = 17'd32772;  // 12 * DIV_BIAS
   localparam logic [15:0]              DIV_RECIP  = 16'd43691;  // ceil(2^19 / 12)
   localparam logic signed [YEAR_W-1:0] DIV_BIAS   = 18'sd2731;
   localparam logic signed [YEAR_W-1:0] EPOCH_YEAR = 18'sd1970;
   localparam logic signed [YEAR_W-1:0] YEAR_LIMIT = 18'sd9999;
   localparam logic [15:0]              EPOCH_LEAP = 16'd493;    // leap days before 1970
   localparam logic [15:0]              YEAR_DAYS  = 16'd365;

   function automatic logic [4:0] month_len(input logic leap, input logic [3:0] m);
      logic [4:0] len;
      case (m) inside
         4'd2:                      len = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
         default:                   len = 5'd31;
      endcase
      return len;
   endfunction

   function automatic logic [8:0] days_before(input logic leap, input logic [3:0] m);
      logic [8:0] cum;
      case (m)
         4'd1:    cum = 9'd0;
         4'd2:    cum = 9'd31;
         4'd3:    cum = 9'd59;
         4'd4:    cum = 9'd90;
         4'd5:    cum = 9'd120;
         4'd6:    cum = 9'd151;
         4'd7:    cum = 9'd181;
         4'd8:    cum = 9'd212;
         4'd9:    cum = 9'd243;
         4'd10:   cum = 9'd273;
         4'd11:   cum = 9'd304;
         4'd12:   cum = 9'd334;
         default: cum = 9'd0;
      endcase
      if (leap && m > 4'd2) begin
         cum = cum + 9'd1;
      end
      return cum;
   endfunction

endpackage

`default_nettype wire

[hdl/calendar_date_offset_adder.sv]
// Top level of the calendar date offset adder: controller plus datapath.
// Uses cdoa_pkg, cdoa_ctrl and cdoa_datapath.
//
// Adds a signed count of days, months or years to a date (leap year every fourth
// year) and returns the new date, its day count since 1970-01-01 modulo 65536 and
// a flag for a year outside 0..9999. One request is worked at a time. Adding days
// walks the calendar one month per cycle until the count fits the month. Adding
// months divides by twelve with a reciprocal multiply, then moves a day past the
// new month's end to the first of the next; years are added and the day fixed
// alike, and an unused cmd returns the loaded date. A finished request waits
// further while the previous result is still held by rsp_ready low. The result
// register lets a new request be taken while the last result waits on rsp_ready.
`default_nettype none

module calendar_date_offset_adder (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_ready,
   input  cdoa_pkg::req_type  req_payload,
   output logic               rsp_valid,
   input  wire                rsp_ready,
   output cdoa_pkg::rsp_type  rsp_payload
);
   import cdoa_pkg::*;

   ctl_cmd_type    ctl;
   ctl_status_type status;

   cdoa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .ctl       (ctl)
   );

   cdoa_datapath u_datapath (
      .clock       (clock),
      .req_payload (req_payload),
      .ctl         (ctl),
      .status      (status),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

[hdl/cdoa_datapath.sv]
// Datapath of the calendar date offset adder: date registers, month stepper,
// reciprocal divide by twelve, epoch day count and result register. Uses cdoa_pkg.
`default_nettype none

module cdoa_datapath (
   input  wire                      clock,
   input  cdoa_pkg::req_type        req_payload,
   input  cdoa_pkg::ctl_cmd_type    ctl,
   output cdoa_pkg::ctl_status_type status,
   output cdoa_pkg::rsp_type        rsp_payload
);
   import cdoa_pkg::*;

   cmd_code_type              cmd_ff, cmd_in;
   logic signed [YEAR_W-1:0]  year_ff, year_in;
   logic [3:0]                month_ff, month_in;
   logic [4:0]                day_ff, day_in;
   logic signed [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [DIV_BITS-1:0]       num_ff, num_in;
   logic [QUO_W-1:0]          quo_ff, quo_in;
   rsp_type                   rsp_ff, rsp_in;

   logic [3:0]               ld_month;
   logic [4:0]               ld_len;
   logic [4:0]               ld_day;
   logic [4:0]               len_cur;
   logic signed [YEAR_W-1:0] day_ext, cnt_ext, len_ext, sum;
   logic                     fit;
   logic [3:0]               prev_month;
   logic signed [YEAR_W-1:0] prev_year;
   logic [31:0]              div_prod;
   logic [3:0]               div_rem;
   logic [15:0]              ep_dy, ep_mul, ep_quarter;
   logic signed [YEAR_W-1:0] quarter;
   logic [8:0]               ep_cum;

   always_comb begin
      ld_month = (req_payload.in_month == 4'd0) ? 4'd1 :
                 (req_payload.in_month > MONTHS) ? MONTHS : req_payload.in_month;
      ld_len   = month_len(req_payload.in_year[1:0] == 2'd0, ld_month);
      ld_day   = (req_payload.in_day == 5'd0) ? 5'd1 :
                 (req_payload.in_day > ld_len) ? ld_len : req_payload.in_day;

      len_cur = month_len(year_ff[1:0] == 2'd0, month_ff);
      day_ext = {13'd0, day_ff};
      len_ext = {13'd0, len_cur};
      cnt_ext = {cnt_ff[CNT_W-1], cnt_ff};
      sum     = day_ext + cnt_ext;
      fit     = cnt_ff[CNT_W-1] ? (sum >= 18'sd1) : (sum <= len_ext);

      prev_month = (month_ff == 4'd1) ? MONTHS : month_ff - 4'd1;
      prev_year  = (month_ff == 4'd1) ? year_ff - 18'sd1 : year_ff;

      // quotient by reciprocal multiply, remainder from the low bits of num - 12 * quo
      div_prod = 32'(num_ff) * 32'(DIV_RECIP);
      div_rem  = num_ff[3:0] - {quo_ff[0], 3'b000} - {quo_ff[1:0], 2'b00};

      ep_dy      = 16'(year_ff - EPOCH_YEAR);
      ep_mul     = 16'(ep_dy * YEAR_DAYS);
      quarter    = (year_ff + 18'sd3) >>> 2;
      ep_quarter = quarter[15:0];
      ep_cum     = days_before(year_ff[1:0] == 2'd0, month_ff);

      cmd_in   = cmd_ff;
      year_in  = year_ff;
      month_in = month_ff;
      day_in   = day_ff;
      cnt_in   = cnt_ff;
      num_in   = num_ff;
      quo_in   = quo_ff;
      rsp_in   = rsp_ff;

      if (ctl.load) begin
         cmd_in   = req_payload.cmd;
         year_in  = {4'd0, req_payload.in_year};
         month_in = ld_month;
         day_in   = ld_day;
         cnt_in   = {req_payload.amount[15], req_payload.amount};
         num_in   = DIV_OFFSET + {req_payload.amount[15], req_payload.amount}
                    + {13'd0, ld_month - 4'd1};
      end

      if (ctl.day_step) begin
         if (fit) begin
            day_in = sum[4:0];
            cnt_in = '0;
         end else if (!cnt_ff[CNT_W-1]) begin
            cnt_in = cnt_ff - CNT_W'(len_cur) + CNT_W'(day_ff) - 17'sd1;
            day_in = 5'd1;
            if (month_ff == MONTHS) begin
               month_in = 4'd1;
               year_in  = year_ff + 18'sd1;
            end else begin
               month_in = month_ff + 4'd1;
            end
         end else begin
            cnt_in   = cnt_ff + CNT_W'(day_ff);
            month_in = prev_month;
            year_in  = prev_year;
            day_in   = month_len(prev_year[1:0] == 2'd0, prev_month);
         end
      end

      if (ctl.div_step) begin
         quo_in = div_prod[DIV_SHIFT +: QUO_W];
      end

      if (ctl.div_apply) begin
         year_in  = year_ff + YEAR_W'(quo_ff) - DIV_BIAS;
         month_in = div_rem + 4'd1;
      end

      if (ctl.year_add) begin
         year_in = year_ff + {cnt_ff[CNT_W-1], cnt_ff};
      end

      if (ctl.fix) begin
         if (day_ff > len_cur) begin
            day_in = 5'd1;
            if (month_ff == MONTHS) begin
               month_in = 4'd1;
               year_in  = year_ff + 18'sd1;
            end else begin
               month_in = month_ff + 4'd1;
            end
         end
      end

      if (ctl.store) begin
         rsp_in.out_year    = year_ff[13:0];
         rsp_in.out_month   = month_ff;
         rsp_in.out_day     = day_ff;
         rsp_in.epoch_days  = ep_mul + ep_quarter - EPOCH_LEAP + 16'(ep_cum)
                              + 16'(day_ff) - 16'd1;
         rsp_in.range_error = year_ff[YEAR_W-1] || (year_ff > YEAR_LIMIT);
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      year_ff  <= year_in;
      month_ff <= month_in;
      day_ff   <= day_in;
      cnt_ff   <= cnt_in;
      num_ff   <= num_in;
      quo_ff   <= quo_in;
      rsp_ff   <= rsp_in;
   end

   assign status.cmd     = cmd_ff;
   assign status.day_fit = fit;
   assign rsp_payload    = rsp_ff;

endmodule

`default_nettype wire

[hdl/cdoa_ctrl.sv]
// Controller of the calendar date offset adder: sequences one request through
// the datapath and owns both handshakes. Uses cdoa_pkg.
`default_nettype none

module cdoa_ctrl (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  wire                      rsp_ready,
   input  cdoa_pkg::ctl_status_type status,
   output cdoa_pkg::ctl_cmd_type    ctl
);
   import cdoa_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_DAYS,
      ST_DIV,
      ST_APPLY,
      ST_FIX,
      ST_DONE
   } state_type;

   state_type            state_ff, state_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 out_free;

   always_comb begin
      out_free     = !rsp_valid_ff || rsp_ready;
      ctl          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ctl.load = 1'b1;
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            case (status.cmd)
               CMD_ADD_DAYS:   state_in = ST_DAYS;
               CMD_ADD_MONTHS: state_in = ST_DIV;
               CMD_ADD_YEARS: begin
                  ctl.year_add = 1'b1;
                  state_in     = ST_FIX;
               end
               default:        state_in = ST_DONE;
            endcase
         end
         ST_DAYS: begin
            ctl.day_step = 1'b1;
            if (status.day_fit) begin
               state_in = ST_DONE;
            end
         end
         ST_DIV: begin
            ctl.div_step = 1'b1;
            state_in     = ST_APPLY;
         end
         ST_APPLY: begin
            ctl.div_apply = 1'b1;
            state_in      = ST_FIX;
         end
         ST_FIX: begin
            ctl.fix  = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               ctl.store    = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire
